@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the rtl files
// each macro takes a label, the clock, the active-low reset and the property terms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/tscc_pkg.sv @@
// ----------------------------------------------------------------------------
// tscc_pkg
// Types and constants of the threshold sweep confusion counter.
// ----------------------------------------------------------------------------
`default_nettype none

package tscc_pkg;

  // field widths
  localparam int CONF_W  = 16;
  localparam int COV_W   = 15;
  localparam int STEP_W  = 6;
  localparam int CNT_W   = 11;
  localparam int ACT_W   = 2;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 16;

  // threshold division: |i * max| stays below 2^21
  localparam int DIV_W     = 21;
  localparam int DIV_CNT_W = 5;

  // request actions
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SWEEP = 2'd2;

  // register indexes
  localparam logic [CFG_A_W-1:0] CFG_INIT_MAX  = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_COV_THR   = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_NUM_STEPS = 2'd2;

  // register reset values
  localparam logic [COV_W-1:0]  COV_THR_RST   = 15'd12800;
  localparam logic [STEP_W-1:0] NUM_STEPS_RST = 6'd10;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [CONF_W-1:0] confidence;
    logic [COV_W-1:0]         coverage;
  } in_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]        step_index;
    logic signed [CONF_W-1:0] threshold;
    logic [CNT_W-1:0]         true_pos;
    logic [CNT_W-1:0]         false_pos;
    logic [CNT_W-1:0]         false_neg;
    logic [CNT_W-1:0]         true_neg;
    logic                     last_of_run;
  } out_item_t;

  typedef struct packed {
    logic signed [CONF_W-1:0] conf;
    logic [COV_W-1:0]         cov;
  } score_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/tscc_div.sv @@
// ----------------------------------------------------------------------------
// tscc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tscc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [tscc_pkg::DIV_W-1:0]   dividend,
  input  wire logic [tscc_pkg::STEP_W-1:0]  divisor,
  output logic                              done,
  output logic [tscc_pkg::DIV_W-1:0]        quotient
);
  import tscc_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [STEP_W-1:0]     rem_r;
  logic [DIV_W-1:0]      quo_r;
  logic [STEP_W-1:0]     dsr_r;
  logic [STEP_W:0]       rem_sh;
  logic                  fits;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    fits   = rem_sh >= {1'b0, dsr_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? STEP_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[STEP_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ hw/rtl/threshold_sweep_confusion_counter.sv @@
// ----------------------------------------------------------------------------
// threshold_sweep_confusion_counter
// Score store with a threshold sweep that counts the confusion matrix.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake: add a score, clear the store or sweep.
//   out_* : one result per threshold step of a sweep, last_of_run on the final.
//   cfg_* : register writes, always ready; write only while the block is idle.
// Request handling:
//   add and clear are taken back to back.
//   a sweep takes num_steps+1 threshold steps (two when num_steps is 0).
//   each step forms the i*max product, runs the bit-serial threshold divide,
//   scans the stored scores through the score memory read port and hands
//   the result to the output register.
//   in_ready stays low during a sweep.
// Reset:
//   store empty, running max 0, coverage threshold 12800, num_steps 10.
//   the score memory is not cleared; only entries below the count are read.
// Stall:
//   a result waits in the output register; the next step is computed in the
//   meantime and holds until the register frees up. after the last result
//   is loaded, the block takes new requests while that result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module threshold_sweep_confusion_counter #(
  parameter int MAX_SCORES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire tscc_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output tscc_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tscc_pkg::CFG_A_W-1:0]   cfg_index,
  input  wire logic [tscc_pkg::CFG_D_W-1:0]   cfg_data
);
  import tscc_pkg::*;

  localparam int AW = (MAX_SCORES > 1) ? $clog2(MAX_SCORES) : 1;
  localparam int CW = $clog2(MAX_SCORES + 1);

  // registers
  state_t                    state_r, state_nxt;
  logic signed [CONF_W-1:0]  run_max_r;
  logic [COV_W-1:0]          cov_thr_r;
  logic [STEP_W-1:0]         num_steps_r;
  logic [STEP_W-1:0]         steps_r;
  logic [STEP_W-1:0]         step_r;
  logic [CW-1:0]             count_r;
  logic signed [CONF_W-1:0]  thr_r;
  logic [CW-1:0]             rd_idx_r;
  logic                      rd_vld_r;
  score_entry_t              rd_data_r;
  logic [CW-1:0]             tp_r, fp_r, fn_r, tn_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  score_entry_t              mem [MAX_SCORES];

  // control
  logic                      in_fire;
  logic                      cfg_fire;
  logic                      div_start;
  logic                      div_done;
  logic [DIV_W-1:0]          div_quo;
  logic [DIV_W-1:0]          div_neg;
  logic [CONF_W-1:0]         max_mag;
  logic [DIV_W-1:0]          prod_mag;
  logic                      rd_en;
  logic                      scan_done;
  logic                      emit_fire;
  logic                      last_step;
  logic                      actual;
  logic                      pred;
  logic                      add_ok;

  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;
  assign last_step = step_r == steps_r;
  assign add_ok    = count_r < CW'(MAX_SCORES);

  // product magnitude of step index and running max
  always_comb begin
    max_mag  = run_max_r[CONF_W-1] ? CONF_W'(-run_max_r) : run_max_r;
    prod_mag = DIV_W'(step_r) * DIV_W'(max_mag);
    div_neg  = DIV_W'(~div_quo + 1'b1);
  end

  tscc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag),
    .divisor  (steps_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // scan read issue and classification of the returned entry
  always_comb begin
    rd_en     = (state_r == S_SCAN) && (rd_idx_r < count_r);
    scan_done = !rd_en && !rd_vld_r;
    actual    = rd_data_r.cov > cov_thr_r;
    pred      = rd_data_r.conf >= thr_r;
    emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.action == ACT_SWEEP) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_nxt = last_step ? S_IDLE : S_PREP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE:  in_ready  = 1'b1;
      S_PREP:  div_start = 1'b1;
      default: begin
        in_ready  = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_max_r   <= '0;
      cov_thr_r   <= COV_THR_RST;
      num_steps_r <= NUM_STEPS_RST;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;

      // register writes
      if (cfg_fire) begin
        case (cfg_index)
          CFG_COV_THR:   cov_thr_r   <= cfg_data[COV_W-1:0];
          CFG_NUM_STEPS: num_steps_r <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end

      // running max: loaded by its register write, raised by a stored add
      if (cfg_fire && cfg_index == CFG_INIT_MAX) begin
        run_max_r <= cfg_data;
      end else if (in_fire && in_data.action == ACT_ADD && add_ok &&
                   in_data.confidence > run_max_r) begin
        run_max_r <= in_data.confidence;
      end

      // add and clear requests
      if (in_fire && in_data.action == ACT_ADD && add_ok) begin
        count_r <= count_r + 1'b1;
      end else if (in_fire && in_data.action == ACT_CLEAR) begin
        count_r <= '0;
      end

      // output register
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sweep datapath
  always_ff @(posedge clk) begin
    if (in_fire && in_data.action == ACT_SWEEP) begin
      steps_r <= (num_steps_r == '0) ? STEP_W'(1) : num_steps_r;
      step_r  <= '0;
    end else if (emit_fire) begin
      step_r <= step_r + 1'b1;
    end

    // threshold, truncated toward zero
    if (div_done && state_r == S_DIV) begin
      thr_r    <= run_max_r[CONF_W-1] ? div_neg[CONF_W-1:0] : div_quo[CONF_W-1:0];
      rd_idx_r <= '0;
      tp_r     <= '0;
      fp_r     <= '0;
      fn_r     <= '0;
      tn_r     <= '0;
    end else begin
      if (rd_en) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (pred && actual) tp_r <= tp_r + 1'b1;
        if (pred && !actual) fp_r <= fp_r + 1'b1;
        if (!pred && actual) fn_r <= fn_r + 1'b1;
        if (!pred && !actual) tn_r <= tn_r + 1'b1;
      end
    end

    if (emit_fire) begin
      out_data_r.step_index  <= step_r;
      out_data_r.threshold   <= thr_r;
      out_data_r.true_pos    <= CNT_W'(tp_r);
      out_data_r.false_pos   <= CNT_W'(fp_r);
      out_data_r.false_neg   <= CNT_W'(fn_r);
      out_data_r.true_neg    <= CNT_W'(tn_r);
      out_data_r.last_of_run <= last_step;
    end
  end

  // score memory write port
  always_ff @(posedge clk) begin
    if (in_fire && in_data.action == ACT_ADD && add_ok) begin
      mem[count_r[AW-1:0]] <= '{conf: in_data.confidence, cov: in_data.coverage};
    end
  end

  // score memory read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(MAX_SCORES))
  `ASSERT_SAME(a_scan_bound, clk, rst_n, state_r == S_SCAN, rd_idx_r <= count_r)
  `ASSERT_NEXT(a_last_to_idle, clk, rst_n, emit_fire && last_step, state_r == S_IDLE)
  `ASSERT_SAME(a_no_sweep_loss, clk, rst_n, state_r == S_EMIT, !in_ready)

endmodule

`default_nettype wire

@@ tb/tb_threshold_sweep_confusion_counter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_threshold_sweep_confusion_counter
// Checks the confusion counter against its own model of the score store.
// Directed requests cover the field extremes, the empty store, the zero step
// count and the unused action code. Random phases then change the registers
// and mix adds, clears and sweeps. Both channels idle at random, and one long
// output stall backs up the sweep.
// ----------------------------------------------------------------------------
module tb_threshold_sweep_confusion_counter;
  import tscc_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int STORE_DEPTH  = 1024;
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD    = 1500;
  localparam int CYCLE_LIMIT  = 20000000;
  localparam int PHASE_ITEMS  = 70;

  // codes that the package leaves unnamed
  localparam logic [ACT_W-1:0]   ACT_SPARE = 2'd3;
  localparam logic [CFG_A_W-1:0] CFG_SPARE = 2'd3;

  // confusion counts per threshold step, predicted from the stored scores
  class sweep_scoreboard;
    logic signed [CONF_W-1:0] conf_mem [STORE_DEPTH];
    logic [COV_W-1:0]         cov_mem [STORE_DEPTH];
    int                       score_total;
    logic signed [CONF_W-1:0] peak_conf;
    logic [COV_W-1:0]         cov_limit;
    logic [STEP_W-1:0]        step_reg;
    out_item_t                expected_steps [$];
    bit                       failed;

    function new();
      score_total = 0;
      peak_conf   = '0;
      cov_limit   = COV_THR_RST;
      step_reg    = NUM_STEPS_RST;
      failed      = 0;
    endfunction

    function void note_write(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
      case (idx)
        CFG_INIT_MAX:  peak_conf = val;
        CFG_COV_THR:   cov_limit = val[COV_W-1:0];
        CFG_NUM_STEPS: step_reg = val[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_sweep();
      int        steps;
      int        thr;
      int        tp, fp, fn, tn;
      bit        actual;
      out_item_t e;
      steps = (step_reg == 0) ? 1 : int'(step_reg);
      for (int i = 0; i <= steps; i++) begin
        thr = (i * int'(peak_conf)) / steps;
        tp = 0; fp = 0; fn = 0; tn = 0;
        for (int k = 0; k < score_total; k++) begin
          actual = cov_mem[k] > cov_limit;
          if (int'(conf_mem[k]) >= thr) begin
            if (actual) tp++; else fp++;
          end else begin
            if (actual) fn++; else tn++;
          end
        end
        e.step_index  = STEP_W'(i);
        e.threshold   = CONF_W'(thr);
        e.true_pos    = CNT_W'(tp);
        e.false_pos   = CNT_W'(fp);
        e.false_neg   = CNT_W'(fn);
        e.true_neg    = CNT_W'(tn);
        e.last_of_run = (i == steps);
        expected_steps = {expected_steps, e};
      end
    endfunction

    function void note_request(in_item_t r);
      case (r.action)
        ACT_ADD: begin
          // a full store drops the add and leaves the peak alone
          if (score_total < STORE_DEPTH) begin
            conf_mem[score_total] = r.confidence;
            cov_mem[score_total]  = r.coverage;
            score_total++;
            if (r.confidence > peak_conf) peak_conf = r.confidence;
          end
        end
        ACT_CLEAR: score_total = 0;
        ACT_SWEEP: predict_sweep();
        default: ;
      endcase
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failed = 1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_steps.size() == 0) begin
        $error("result with nothing expected: step_index %0d", got.step_index);
        failed = 1;
        return;
      end
      want = expected_steps.pop_front();
      check_field("step_index", want.step_index, got.step_index);
      check_field("threshold", int'(want.threshold), int'(got.threshold));
      check_field("true_pos", want.true_pos, got.true_pos);
      check_field("false_pos", want.false_pos, got.false_pos);
      check_field("false_neg", want.false_neg, got.false_neg);
      check_field("true_neg", want.true_neg, got.true_neg);
      check_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_A_W-1:0]   cfg_index;
  logic [CFG_D_W-1:0]   cfg_data;

  sweep_scoreboard sb;
  int              cycle_count = 0;
  int              holds_asked = 0;
  bit              tx_steady = 0;

  threshold_sweep_confusion_counter #(
    .MAX_SCORES(STORE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial clk = 0;
  always #HALF_PERIOD clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [CONF_W-1:0] rand_conf();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3:    return CONF_W'(int'($urandom_range(0, 512)) - 256);
      default: return CONF_W'($urandom);
    endcase
  endfunction

  // coverage around the current limit as well as anywhere in the field
  function automatic logic [COV_W-1:0] rand_cov();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 15'h7FFF;
      2:       return sb.cov_limit;
      3:       return sb.cov_limit + 15'd1;
      4, 5, 6: return COV_W'($urandom_range(0, 25600));
      default: return COV_W'($urandom);
    endcase
  endfunction

  // result receiver with random stalls and the long hold-off on request
  initial begin
    int hold_left;
    int stall_left;
    int holds_served;
    bit rx_steady;
    hold_left = 0;
    stall_left = 0;
    holds_served = 0;
    rx_steady = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready = 0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 0;
        stall_left--;
      end else begin
        out_ready = 1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic signed [CONF_W-1:0] conf,
                              input logic [COV_W-1:0] cov);
    in_item_t r;
    int       gap;
    r.action     = act;
    r.confidence = conf;
    r.coverage   = cov;
    if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    in_data  = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // request whose payload fields are unused
  task automatic send_op(input logic [ACT_W-1:0] act);
    send_request(act, CONF_W'($urandom), COV_W'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_write(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // all results in, then room for a trailing add to settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    case ($urandom_range(0, 3))
      0:       write_reg(CFG_INIT_MAX, 16'h8000);
      1:       write_reg(CFG_INIT_MAX, 16'h7FFF);
      2:       write_reg(CFG_INIT_MAX, 16'h0000);
      default: write_reg(CFG_INIT_MAX, CFG_D_W'($urandom));
    endcase
    case ($urandom_range(0, 3))
      0:       write_reg(CFG_COV_THR, 16'd0);
      1:       write_reg(CFG_COV_THR, 16'd25600);
      2:       write_reg(CFG_COV_THR, 16'hFFFF);
      default: write_reg(CFG_COV_THR, CFG_D_W'($urandom_range(0, 25600)));
    endcase
    case ($urandom_range(0, 4))
      0:       write_reg(CFG_NUM_STEPS, 16'd0);
      1:       write_reg(CFG_NUM_STEPS, 16'd1);
      2:       write_reg(CFG_NUM_STEPS, 16'd63);
      default: write_reg(CFG_NUM_STEPS, CFG_D_W'($urandom_range(1, 63)));
    endcase
  endtask

  initial begin
    int sent;
    int r;
    sb        = new();
    rst_n     = 0;
    in_valid  = 0;
    in_data   = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset settings: empty store, ignored code, field extremes
    send_op(ACT_SWEEP);
    send_op(ACT_SPARE);
    send_request(ACT_ADD, 16'sh7FFF, 15'd25600);
    send_request(ACT_ADD, 16'sh8000, 15'd0);
    send_request(ACT_ADD, 16'sh0000, 15'd12800);
    send_request(ACT_ADD, 16'sh0000, 15'd12801);
    send_request(ACT_ADD, 16'sh0100, 15'h7FFF);
    send_request(ACT_ADD, -16'sd1, 15'd12801);
    send_request(ACT_ADD, 16'sh5555, 15'h2AAA);
    send_request(ACT_ADD, 16'shAAAA, 15'h5555);
    send_op(ACT_SPARE);
    send_op(ACT_SWEEP);
    // clear keeps the peak
    send_op(ACT_CLEAR);
    send_op(ACT_SWEEP);
    send_request(ACT_ADD, 16'sd100, 15'd0);
    send_request(ACT_ADD, -16'sd100, 15'd25600);
    send_op(ACT_SWEEP);
    wait_idle();

    // zero steps, most negative peak, zero coverage limit, spare index
    write_reg(CFG_NUM_STEPS, 16'd0);
    write_reg(CFG_INIT_MAX, 16'h8000);
    write_reg(CFG_COV_THR, 16'd0);
    write_reg(CFG_SPARE, CFG_D_W'($urandom));
    send_request(ACT_ADD, 16'sh8000, 15'd1);
    send_request(ACT_ADD, -16'sd16384, 15'd0);
    send_op(ACT_SWEEP);
    wait_idle();

    // most steps, top peak, coverage limit at its widest value
    write_reg(CFG_NUM_STEPS, 16'd63);
    write_reg(CFG_INIT_MAX, 16'h7FFF);
    write_reg(CFG_COV_THR, 16'hFFFF);
    send_request(ACT_ADD, 16'sh7FFF, 15'h7FFF);
    send_request(ACT_ADD, 16'sd100, 15'h7FFE);
    send_op(ACT_SWEEP);
    wait_idle();

    // long output hold while the sweeps keep coming
    write_reg(CFG_NUM_STEPS, CFG_D_W'(NUM_STEPS_RST));
    write_reg(CFG_INIT_MAX, 16'h0000);
    write_reg(CFG_COV_THR, CFG_D_W'(COV_THR_RST));
    send_op(ACT_CLEAR);
    holds_asked++;
    tx_steady = 1;
    repeat (6) send_request(ACT_ADD, rand_conf(), rand_cov());
    send_op(ACT_SWEEP);
    repeat (3) send_request(ACT_ADD, rand_conf(), rand_cov());
    send_op(ACT_SWEEP);
    tx_steady = 0;

    // random phases, new settings each time
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      random_config();
      if ($urandom_range(0, 1) == 0) send_op(ACT_CLEAR);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          send_request(ACT_ADD, rand_conf(), rand_cov());
          sent++;
        end else if (r < 88) begin
          send_op(ACT_SWEEP);
          sent++;
        end else if (r < 95) begin
          send_op(ACT_CLEAR);
          sent++;
        end else begin
          send_op(ACT_SPARE);
        end
      end
      send_op(ACT_SWEEP);
    end
    wait_idle();

    if (!sb.failed && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
